// ===== src/crt_pkg.sv =====
// ----------------------------------------------------------------------------
// crt_pkg: shared constants for the CRT solver
// Widths, status codes and default sizes used by the core and its units.
// ----------------------------------------------------------------------------
package crt_pkg;
  localparam int unsigned MaxEquationsDefault = 8;
  localparam int unsigned WideW = 64;
  localparam int unsigned NarrowW = 8;
  localparam logic [1:0] StatusOk = 2'd0;
  localparam logic [1:0] StatusNoInverse = 2'd1;
  localparam logic [1:0] StatusOverflow = 2'd2;

  // Request from the sequencer to the arithmetic unit
  localparam logic [1:0] OpMulMod = 2'd0;
  localparam logic [1:0] OpDivMod = 2'd1;

  typedef struct packed {
    logic             start;
    logic [1:0]       op;
    logic [WideW-1:0] a;
    logic [WideW-1:0] b;
    logic [WideW-1:0] m;
  } arith_req_t;

  typedef struct packed {
    logic             done;
    logic [WideW-1:0] quo;
    logic [WideW-1:0] res;
  } arith_rsp_t;
endpackage

// ===== src/crt_solver_core.sv =====
// ----------------------------------------------------------------------------
// crt_solver_core: Chinese remainder theorem solver
// Collects congruences, then solves them with one shared serial unit.
// ----------------------------------------------------------------------------
// Input stream: one congruence per request, tdata = {modulus, residue},
// tlast marks the final congruence. Requests are accepted one per cycle while loading.
// After the last request the block drops s_axis_tready and solves.
// Each request to the shared bit-serial unit is issued, runs 64 bit steps
// and then returns. For each stored equation the block divides M by m_i,
// reduces the cofactor mod m_i, then searches the inverse upward from 1
// with one 8 x 8 multiply and a serial reduction per candidate (up to 254
// candidates), then does two serial modular multiplies.
// The result waits in the output register until m_axis_tready; loading of
// the next system goes on meanwhile, and its result is held back until the
// register is free. Reset clears the count and flags and sets the product
// to one; the equation stores need no clearing. Output tdata is
// {product_modulus, solution}, tuser is status.
// ----------------------------------------------------------------------------
module crt_solver_core #(
  parameter int unsigned MaxEquations = crt_pkg::MaxEquationsDefault
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [15:0]  s_axis_tdata,   // residue[7:0], modulus[15:8]
  input  logic         s_axis_tlast,   // last_item
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [127:0] m_axis_tdata,   // solution[63:0], product_modulus[127:64]
  output logic [1:0]   m_axis_tuser    // status[1:0]
);
  localparam int unsigned W = crt_pkg::WideW;
  localparam int unsigned IdxW = (MaxEquations > 1) ? $clog2(MaxEquations) : 1;
  localparam int unsigned CntW = $clog2(MaxEquations + 1);

  localparam logic [3:0] StLoad = 4'd0, StCheck = 4'd1, StDiv = 4'd2,
    StCofMod = 4'd3, StInvMul = 4'd4, StInvMod = 4'd5, StTerm1 = 4'd6,
    StTerm2 = 4'd7, StAcc = 4'd8, StOut = 4'd9, StWaitDiv = 4'd10,
    StWaitCof = 4'd11, StWaitInv = 4'd12, StWaitT1 = 4'd13, StWaitT2 = 4'd14;

  logic [7:0] res_mem [MaxEquations];
  logic [7:0] mod_mem [MaxEquations];

  logic [3:0]      st_q, st_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [IdxW-1:0] k_q, k_d;
  logic            ovf_q, ovf_d, low_q, low_d;
  logic [W-1:0]    prod_q, prod_d, acc_q, acc_d, cof_q, cof_d, term_q, term_d;
  logic [7:0]      c_q, c_d, x_q, x_d;
  logic [15:0]     cx_q, cx_d;
  logic            ov_q, ov_d;
  logic [W-1:0]    sol_q, sol_d, pm_q, pm_d;
  logic [1:0]      stat_q, stat_d, ost_q, ost_d;
  logic [7:0]      m_k_q, r_k_q;
  logic            acc_in;
  logic [W:0]      sum;
  crt_pkg::arith_req_t req;
  crt_pkg::arith_rsp_t rsp;

  assign s_axis_tready = (st_q == StLoad);
  assign acc_in = s_axis_tvalid && s_axis_tready;

  // Store congruences while room remains; read the entry for the next index
  always_ff @(posedge clk_i) begin
    if (acc_in && (cnt_q < CntW'(MaxEquations))) begin
      res_mem[cnt_q[IdxW-1:0]] <= s_axis_tdata[7:0];
      mod_mem[cnt_q[IdxW-1:0]] <= s_axis_tdata[15:8];
    end
    m_k_q <= mod_mem[k_d];
    r_k_q <= res_mem[k_d];
  end

  crt_arith u_arith (.clk_i(clk_i), .rst_ni(rst_ni), .req_i(req), .rsp_o(rsp));

  // Sequence the solve through the shared unit
  always_comb begin
    st_d = st_q; cnt_d = cnt_q; k_d = k_q; ovf_d = ovf_q; low_d = low_q;
    prod_d = prod_q; acc_d = acc_q; cof_d = cof_q; term_d = term_q;
    c_d = c_q; x_d = x_q; cx_d = cx_q; ov_d = ov_q;
    sol_d = sol_q; pm_d = pm_q; stat_d = stat_q; ost_d = ost_q;
    req = '0; sum = '0;
    case (st_q)
      StLoad: begin
        if (acc_in) begin
          if (cnt_q < CntW'(MaxEquations)) begin
            cnt_d = cnt_q + CntW'(1);
            prod_d = W'(prod_q * s_axis_tdata[15:8]);
            if (s_axis_tdata[15:8] < 8'd2) low_d = 1'b1;
          end else begin
            ovf_d = 1'b1;
          end
          if (s_axis_tlast) begin
            k_d = '0; acc_d = '0; st_d = StCheck;
          end
        end
      end
      StCheck: begin
        if (ovf_q) begin
          stat_d = crt_pkg::StatusOverflow; st_d = StOut;
        end else if (low_q) begin
          stat_d = crt_pkg::StatusNoInverse; st_d = StOut;
        end else begin
          st_d = StDiv;
        end
      end
      StDiv: begin
        req.start = 1'b1; req.op = crt_pkg::OpDivMod;
        req.a = prod_q; req.m = {56'd0, m_k_q}; st_d = StWaitDiv;
      end
      StWaitDiv: if (rsp.done) begin
        cof_d = rsp.quo; st_d = StCofMod;
      end
      StCofMod: begin
        req.start = 1'b1; req.op = crt_pkg::OpDivMod;
        req.a = cof_q; req.m = {56'd0, m_k_q}; st_d = StWaitCof;
      end
      StWaitCof: if (rsp.done) begin
        c_d = rsp.res[7:0]; x_d = 8'd1; st_d = StInvMul;
      end
      StInvMul: begin
        if (x_q >= m_k_q) begin
          stat_d = crt_pkg::StatusNoInverse; st_d = StOut;
        end else begin
          cx_d = c_q * x_q; st_d = StInvMod;
        end
      end
      StInvMod: begin
        req.start = 1'b1; req.op = crt_pkg::OpDivMod;
        req.a = {48'd0, cx_q}; req.m = {56'd0, m_k_q}; st_d = StWaitInv;
      end
      StWaitInv: if (rsp.done) begin
        if (rsp.res == W'(1)) begin
          st_d = StTerm1;
        end else begin
          x_d = x_q + 8'd1; st_d = StInvMul;
        end
      end
      StTerm1: begin
        // cofactor is below M, so it is the addend; the residue only steers bits
        req.start = 1'b1; req.op = crt_pkg::OpMulMod;
        req.a = cof_q; req.b = {56'd0, r_k_q}; req.m = prod_q; st_d = StWaitT1;
      end
      StWaitT1: if (rsp.done) begin
        term_d = rsp.res; st_d = StTerm2;
      end
      StTerm2: begin
        req.start = 1'b1; req.op = crt_pkg::OpMulMod;
        req.a = term_q; req.b = {56'd0, x_q}; req.m = prod_q; st_d = StWaitT2;
      end
      StWaitT2: if (rsp.done) begin
        term_d = rsp.res; st_d = StAcc;
      end
      StAcc: begin
        sum = {1'b0, acc_q} + {1'b0, term_q};
        acc_d = (sum >= {1'b0, prod_q}) ? W'(sum - {1'b0, prod_q}) : W'(sum);
        if (CntW'(k_q) == cnt_q - CntW'(1)) begin
          stat_d = crt_pkg::StatusOk; st_d = StOut;
        end else begin
          k_d = k_q + IdxW'(1); st_d = StDiv;
        end
      end
      StOut: begin
        if (!ov_q) begin
          ov_d = 1'b1;
          ost_d = stat_q;
          sol_d = (stat_q == crt_pkg::StatusOk) ? acc_q : '0;
          pm_d = (stat_q == crt_pkg::StatusOk) ? prod_q : '0;
          cnt_d = '0; ovf_d = 1'b0; low_d = 1'b0; prod_d = W'(1); acc_d = '0;
          st_d = StLoad;
        end
      end
      default: st_d = StLoad;
    endcase
    if (ov_q && m_axis_tready) ov_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StLoad; cnt_q <= '0; ovf_q <= 1'b0; low_q <= 1'b0;
      prod_q <= W'(1); acc_q <= '0; ov_q <= 1'b0;
    end else begin
      st_q <= st_d; cnt_q <= cnt_d; ovf_q <= ovf_d; low_q <= low_d;
      prod_q <= prod_d; acc_q <= acc_d; ov_q <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    k_q <= k_d; cof_q <= cof_d; term_q <= term_d; c_q <= c_d; x_q <= x_d;
    cx_q <= cx_d; sol_q <= sol_d; pm_q <= pm_d; stat_q <= stat_d;
    ost_q <= ost_d;
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata = {pm_q, sol_q};
  assign m_axis_tuser = ost_q;
endmodule

// ===== src/crt_arith.sv =====
// ----------------------------------------------------------------------------
// crt_arith: shared bit-serial arithmetic unit
// One bit per cycle: modular multiply by double-and-add, or restoring divide.
// ----------------------------------------------------------------------------
module crt_arith (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  crt_pkg::arith_req_t req_i,
  output crt_pkg::arith_rsp_t rsp_o
);
  localparam int unsigned W = crt_pkg::WideW;

  logic         busy_q, busy_d;
  logic [1:0]   op_q, op_d;
  logic [5:0]   bit_q, bit_d;
  logic [W-1:0] a_q, a_d, b_q, b_d, m_q, m_d, r_q, r_d, quo_q, quo_d;
  logic         done_q, done_d;
  logic [W:0]   dbl;
  logic [W:0]   add;
  logic [W-1:0] r1;

  always_comb begin
    busy_d = busy_q; op_d = op_q; bit_d = bit_q; a_d = a_q; b_d = b_q;
    m_d = m_q; r_d = r_q; quo_d = quo_q; done_d = 1'b0;
    dbl = '0; add = '0; r1 = '0;
    if (req_i.start) begin
      busy_d = 1'b1; op_d = req_i.op; bit_d = 6'd63;
      a_d = req_i.a; b_d = req_i.b; m_d = req_i.m; r_d = '0; quo_d = '0;
    end else if (busy_q) begin
      case (op_q)
        crt_pkg::OpMulMod: begin
          // double, reduce, then add a when the bit is set
          dbl = {r_q, 1'b0};
          r1 = (dbl >= {1'b0, m_q}) ? W'(dbl - {1'b0, m_q}) : W'(dbl);
          add = {1'b0, r1} + {1'b0, a_q};
          if (b_q[bit_q]) begin
            r_d = (add >= {1'b0, m_q}) ? W'(add - {1'b0, m_q}) : W'(add);
          end else begin
            r_d = r1;
          end
        end
        default: begin
          // restoring divide of a by m, one quotient bit a cycle
          dbl = {r_q, a_q[bit_q]};
          if (dbl >= {1'b0, m_q}) begin
            r_d = W'(dbl - {1'b0, m_q});
            quo_d[bit_q] = 1'b1;
          end else begin
            r_d = W'(dbl);
          end
        end
      endcase
      if (bit_q == 6'd0) begin
        busy_d = 1'b0; done_d = 1'b1;
      end else begin
        bit_d = bit_q - 6'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0;
    end else begin
      busy_q <= busy_d; done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q <= op_d; bit_q <= bit_d; a_q <= a_d; b_q <= b_d;
    m_q <= m_d; r_q <= r_d; quo_q <= quo_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo = quo_q;
  assign rsp_o.res = r_q;
endmodule

// ===== src/crt_solver_checker.sv =====
// ----------------------------------------------------------------------------
// crt_solver_checker: port-level checks for the CRT solver
// Watches the stream ports of the core over time.
// ----------------------------------------------------------------------------
module crt_solver_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         s_axis_tlast,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [127:0] m_axis_tdata,
  input logic [1:0]   m_axis_tuser
);
  // hold a stalled result
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result changed");
  // a final request closes the input side
  a_close: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
    else $error("ready after last request");
  // status is never out of range
  a_stat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tuser <= crt_pkg::StatusOverflow)
    else $error("bad status");
  // failed systems report zero values
  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser != crt_pkg::StatusOk |-> m_axis_tdata == '0)
    else $error("nonzero data on failure");
endmodule

bind crt_solver_core crt_solver_checker u_checker (.*);

// ===== sim/crt_solver_core_tb.sv =====
// ----------------------------------------------------------------------------
// crt_solver_core_tb: self-checking bench for the CRT solver core
// Streams systems of congruences into the core, predicts each solution,
// product and status in a scoreboard, and compares every result it returns.
// ----------------------------------------------------------------------------
module crt_solver_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MaxEq = crt_pkg::MaxEquationsDefault;
  localparam int unsigned ItemTarget = 750;
  localparam longint unsigned CycleLimit = 50000000;
  localparam int unsigned DrainCycles = 300;

  // Predicts one CRT result per closed system and checks the returned ones
  class crt_scoreboard;
    logic [7:0]  res_q[MaxEq];
    logic [7:0]  mod_q[MaxEq];
    int unsigned eq_cnt;
    bit          ovf;
    logic [63:0] prod;
    logic [63:0] exp_sol[$];
    logic [63:0] exp_prod[$];
    logic [1:0]  exp_stat[$];
    int unsigned errors;

    function new();
      eq_cnt = 0;
      ovf = 0;
      prod = 64'd1;
      errors = 0;
    endfunction

    function logic [63:0] mul_mod(logic [63:0] a, logic [63:0] b, logic [63:0] m);
      logic [127:0] p;
      p = {64'd0, a} * {64'd0, b};
      return 64'(p % {64'd0, m});
    endfunction

    function int unsigned inverse_of(logic [63:0] cof, int unsigned m);
      int unsigned c;
      c = int'(cof % m);
      for (int unsigned x = 1; x < m; x++) begin
        if ((c * x) % m == 1) return x;
      end
      return 0;
    endfunction

    task report(string what, logic [63:0] got, logic [63:0] want);
      errors++;
      $display("MISMATCH %s: got %0h, want %0h", what, got, want);
    endtask

    // Fold one accepted congruence into the system; close it on last
    task note_request(logic [7:0] r, logic [7:0] m, logic last);
      logic [1:0]  st;
      logic [63:0] acc, cof, term;
      int unsigned inv;
      if (eq_cnt >= MaxEq) begin
        ovf = 1;
      end else begin
        res_q[eq_cnt] = r;
        mod_q[eq_cnt] = m;
        eq_cnt++;
        prod = prod * 64'(m);
      end
      if (!last) return;
      st = crt_pkg::StatusOk;
      acc = 64'd0;
      if (ovf) begin
        st = crt_pkg::StatusOverflow;
      end else begin
        for (int k = 0; k < eq_cnt; k++) begin
          if (mod_q[k] < 2) st = crt_pkg::StatusNoInverse;
        end
      end
      if (st == crt_pkg::StatusOk) begin
        for (int k = 0; k < eq_cnt; k++) begin
          cof = prod / 64'(mod_q[k]);
          inv = inverse_of(cof, mod_q[k]);
          if (inv == 0) begin
            st = crt_pkg::StatusNoInverse;
            break;
          end
          term = mul_mod(64'(res_q[k]) % prod, cof, prod);
          term = mul_mod(term, 64'(inv), prod);
          acc = 64'(({1'b0, acc} + {1'b0, term}) % {1'b0, prod});
        end
      end
      exp_sol.push_back(st == crt_pkg::StatusOk ? acc : 64'd0);
      exp_prod.push_back(st == crt_pkg::StatusOk ? prod : 64'd0);
      exp_stat.push_back(st);
      eq_cnt = 0;
      ovf = 0;
      prod = 64'd1;
    endtask

    task check_result(logic [63:0] sol, logic [63:0] pm, logic [1:0] st);
      if (exp_stat.size() == 0) begin
        report("unexpected result", sol, 64'd0);
        return;
      end
      if (st !== exp_stat[0]) report("status", 64'(st), 64'(exp_stat[0]));
      if (sol !== exp_sol[0]) report("solution", sol, exp_sol[0]);
      if (pm !== exp_prod[0]) report("product_modulus", pm, exp_prod[0]);
      void'(exp_sol.pop_front());
      void'(exp_prod.pop_front());
      void'(exp_stat.pop_front());
    endtask

    function int unsigned pending();
      return exp_stat.size();
    endfunction
  endclass

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [15:0]  s_axis_tdata = '0;
  logic         s_axis_tlast = 1'b0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [127:0] m_axis_tdata;
  logic [1:0]   m_axis_tuser;

  crt_scoreboard sb = new();
  int unsigned   items_sent = 0;
  bit            idle_on = 1'b1;
  longint unsigned cycles = 0;

  crt_solver_core u_top (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tlast,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Bound the run
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Check returned results and stall the output in random bursts
  int unsigned stall_left = 0;
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      sb.check_result(m_axis_tdata[63:0], m_axis_tdata[127:64], m_axis_tuser);
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 8);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Send one congruence request, with an optional random gap ahead of it
  task automatic send_request(logic [7:0] r, logic [7:0] m, logic last);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {m, r};
    s_axis_tlast <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_request(r, m, last);
    items_sent++;
  endtask

  function automatic int unsigned gcd(int unsigned a, int unsigned b);
    int unsigned t;
    while (b != 0) begin
      t = a % b;
      a = b;
      b = t;
    end
    return a;
  endfunction

  // Well-formed system: pairwise coprime small moduli, random residues
  task automatic send_coprime_system(int unsigned n);
    int unsigned pool[13] = '{2, 3, 4, 5, 7, 9, 11, 13, 16, 17, 19, 23, 25};
    int unsigned picked[$];
    int unsigned c;
    bit ok;
    for (int tries = 0; tries < 40 && picked.size() < n; tries++) begin
      c = pool[$urandom_range(0, 12)];
      ok = 1;
      foreach (picked[i]) if (gcd(picked[i], c) != 1) ok = 0;
      if (ok) picked.push_back(c);
    end
    foreach (picked[i])
      send_request(8'($urandom_range(0, 255)), 8'(picked[i]), i == picked.size() - 1);
  endtask

  // Drop the request line, wait until every expected result is back, settle
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  initial begin
    int unsigned kind, n;
    bit paused;
    paused = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: extremes, bad moduli, non-coprime, full and overflowing systems
    send_request(8'd255, 8'd255, 1'b1);
    send_request(8'd0, 8'd0, 1'b1);
    send_request(8'd7, 8'd1, 1'b1);
    send_request(8'd200, 8'd4, 1'b0);
    send_request(8'd3, 8'd6, 1'b1);
    send_request(8'd2, 8'd3, 1'b0);
    send_request(8'd3, 8'd5, 1'b0);
    send_request(8'd2, 8'd7, 1'b1);
    foreach (sb.res_q[i])
      send_request(8'(i * 37), 8'(i == 0 ? 2 : i == 1 ? 3 : i == 2 ? 5 : i == 3 ? 7 :
                   i == 4 ? 11 : i == 5 ? 13 : i == 6 ? 17 : 19), i == MaxEq - 1);
    for (int i = 0; i <= MaxEq; i++)
      send_request(8'd1, 8'd3, i == MaxEq);
    drain();

    // Random systems; the sender holds off once in the middle
    while (items_sent < ItemTarget) begin
      if (items_sent > ItemTarget - 100) idle_on = 1'b0;
      kind = $urandom_range(0, 19);
      if (kind < 15) begin
        send_coprime_system($urandom_range(1, 4));
      end else if (kind < 18) begin
        n = $urandom_range(1, 2);
        for (int i = 0; i < n; i++)
          send_request(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                       i == n - 1);
      end else if (kind < 19) begin
        n = $urandom_range(MaxEq + 1, MaxEq + 3);
        for (int i = 0; i < n; i++)
          send_request(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                       i == n - 1);
      end else begin
        send_request(8'($urandom_range(0, 255)), 8'($urandom_range(2, 12)), 1'b0);
        send_request(8'($urandom_range(0, 255)), 8'(2 * $urandom_range(1, 6)), 1'b1);
      end
      if (!paused && items_sent > 300) begin
        paused = 1'b1;
        drain();
      end
    end
    s_axis_tlast <= 1'b0;

    drain();
    if (sb.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
